FILE: hdl/sm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 package
// shared constants, types and round functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } t_state;

    // control from the sequencer to the compression unit
    typedef struct packed {
        logic start;
        logic init;
    } t_comp_ctrl;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

FILE: hdl/sm3_hash_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 hash engine core
// streaming sm3 hash: packs message words into blocks, pads, emits digest
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel, big-endian, tuser carrying the
// byte count and tlast marking the final word of a message. A non-final word
// is written into the block buffer; the sixteenth word of a block starts the
// compression unit, which runs 64 rounds, one per cycle, and the block holds
// tready low meanwhile. A final word pads one word per cycle, runs one or two
// compressions, then presents the eight digest words on m_axis, index in
// tuser, tlast on the eighth. The sustained word rate is set by the single
// round unit. A stalled receiver holds the digest word steady, as the index
// does not advance, and the block takes no input until all eight words
// are taken. Reset loads the initial value and clears fill and length; the
// block is then ready for a new message.
// ----------------------------------------------------------------------------
module sm3_hash_engine_core import sm3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [2:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // final_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_digest_word
);

    t_state       r_state, n_state;
    logic [31:0]  r_blk [16];
    logic [3:0]   r_fill;
    logic [63:0]  r_len;
    logic         r_fin;        // padding finished, last compression pending
    logic [2:0]   r_oidx;
    logic         r_start;

    // pending pad: a final word was taken; cleared when the last compression ends
    logic         r_pad_pending;
    logic         r_pad_full;   // pad byte not yet written
    // length words go in only in the block whose pad byte is already placed
    logic         r_len_ok;

    logic         comp_busy, comp_done;
    logic [255:0] cv;
    logic [511:0] blk_flat;
    t_comp_ctrl   ctrl;

    logic         acc, out_acc;
    logic [2:0]   nb;
    logic [63:0]  len_new;
    logic [31:0]  pad_w, keep;
    logic [31:0]  wr_data;
    logic         wr_en;
    logic [31:0]  pad_data;
    logic         comp_final;

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // byte count, first pad word of a final item and the updated message length
    always_comb begin
        nb = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
        unique case (nb)
            3'd1:    keep = 32'hFF000000;
            3'd2:    keep = 32'hFFFF0000;
            3'd3:    keep = 32'hFFFFFF00;
            default: keep = 32'h00000000;
        endcase
        pad_w = (s_axis_tdata & keep) | ({24'd0, PAD_BYTE} << (6'd24 - {nb[1:0], 3'd0}));
        len_new = r_len + (s_axis_tlast ? {58'd0, nb, 3'd0} : 64'd32);
    end

    // next state
    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_data = 32'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    wr_en = 1'b1;
                    if (!s_axis_tlast) begin
                        wr_data = s_axis_tdata;
                        if (r_fill == 4'd15) n_state = ST_COMP;
                    end else begin
                        wr_data = (nb == 3'd4) ? s_axis_tdata : pad_w;
                        // a full final word still owes the pad byte
                        n_state = (r_fill == 4'd15) ? ST_COMP : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_fill == 4'd14) wr_data = r_len[63:32];
                else if (r_fill == 4'd15) wr_data = r_len[31:0];
                else wr_data = 32'd0;
                if (r_fill == 4'd15) n_state = ST_COMP;
            end
            ST_COMP: begin
                if (comp_done) begin
                    if (r_fin) n_state = ST_OUT;
                    else if (r_pad_pending) n_state = ST_PAD;
                    else n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc && r_oidx == 3'd7) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fill        <= '0;
            r_len         <= '0;
            r_fin         <= 1'b0;
            r_oidx        <= '0;
            r_start       <= 1'b0;
            r_pad_pending <= 1'b0;
            r_pad_full    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (n_state == ST_COMP) && (r_state != ST_COMP);
            if (acc) begin
                r_len <= len_new;
                r_pad_pending <= s_axis_tlast;
                r_pad_full    <= s_axis_tlast && (nb == 3'd4);
            end
            if (wr_en) r_fill <= r_fill + 4'd1;
            // first pad-state word after a full final word is the pad byte
            if (r_state == ST_PAD && r_pad_full) r_pad_full <= 1'b0;
            if (comp_final) r_fin <= 1'b1;
            // last compression done: no pad block is pending any more
            if (r_state == ST_COMP && comp_done && r_fin) r_pad_pending <= 1'b0;
            if (r_state == ST_OUT && out_acc) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_fin   <= 1'b0;
                    r_len   <= '0;
                    r_fill  <= '0;
                end
            end
        end
    end

    // padding may need a second block: fill reaching 14 only ends in length
    always_comb begin
        if (r_pad_full) pad_data = {PAD_BYTE, 24'd0};
        else if (r_fill == 4'd14 && r_len_ok) pad_data = r_len[63:32];
        else if (r_fill == 4'd15 && r_len_ok) pad_data = r_len[31:0];
        else pad_data = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_ok <= 1'b0;
        end else if (acc) begin
            r_len_ok <= !(s_axis_tlast && (nb == 3'd4) && r_fill == 4'd15)
                        && !(s_axis_tlast && r_fill >= 4'd14 && nb != 3'd4)
                        && !(s_axis_tlast && nb == 3'd4 && r_fill >= 4'd13);
        end else if (r_state == ST_COMP && comp_done) begin
            r_len_ok <= 1'b1;
        end
    end

    // block buffer
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PAD) begin
            r_blk[r_fill] <= pad_data;
        end else if (wr_en) begin
            r_blk[r_fill] <= wr_data;
        end
    end

    assign comp_final = (r_state == ST_PAD) && (r_fill == 4'd15) && r_len_ok;

    always_comb begin
        for (int k = 0; k < 16; k++) blk_flat[32*k +: 32] = r_blk[k];
        ctrl.start = r_start;
        ctrl.init  = (r_state == ST_OUT) && out_acc && (r_oidx == 3'd7);
    end

    sm3_compress u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_block (blk_flat),
        .o_busy  (comp_busy),
        .o_done  (comp_done),
        .o_cv    (cv)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = cv[32*r_oidx +: 32];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);

    // compression never runs while words are read out or taken in
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        comp_busy |-> (r_state == ST_COMP))
        else $error("compression running outside compress state");
    // fill is back at zero whenever a compression finishes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        comp_done |-> (r_fill == 4'd0))
        else $error("block fill not wrapped at compression end");
    // the digest word index holds while the receiver stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_oidx))
        else $error("digest index moved under stall");
    // a final item marks the last compression once padding completes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        comp_final |=> r_fin)
        else $error("final compression not flagged");

endmodule

FILE: hdl/sm3_compress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 compression unit
// one round per cycle over a 16-word expansion window, 64 rounds per block
// ----------------------------------------------------------------------------
module sm3_compress import sm3_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_comp_ctrl   i_ctrl,
    input  logic [511:0] i_block,   // word 0 in bits 31:0
    output logic         o_busy,
    output logic         o_done,
    output logic [255:0] o_cv       // word 0 in bits 31:0
);

    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [31:0]  r_cv [8];
    logic [5:0]   r_rnd;
    logic         r_busy;
    logic         r_done;

    logic [31:0] w0, w4, wn, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic        lowr;

    // round datapath
    always_comb begin
        lowr = (r_rnd < 6'd16);
        w0   = r_w[0];
        w4   = r_w[4];
        wn   = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7)
               ^ r_w[10];
        tj   = lowr ? T_LOW : T_HIGH;
        a12  = rotl(r_v[0], 5'd12);
        ss1  = rotl(a12 + r_v[4] + rotl(tj, r_rnd[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        if (lowr) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + (w0 ^ w4);
        tt2 = gg + r_v[7] + ss1 + w0;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // chaining value and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_cv[k] <= SM3_IV[32*k +: 32];
        end else if (i_ctrl.init) begin
            for (int k = 0; k < 8; k++) r_cv[k] <= SM3_IV[32*k +: 32];
        end else if (r_busy && r_rnd == 6'd63) begin
            r_cv[0] <= r_cv[0] ^ tt1;
            r_cv[1] <= r_cv[1] ^ r_v[0];
            r_cv[2] <= r_cv[2] ^ rotl(r_v[1], 5'd9);
            r_cv[3] <= r_cv[3] ^ r_v[2];
            r_cv[4] <= r_cv[4] ^ perm0(tt2);
            r_cv[5] <= r_cv[5] ^ r_v[4];
            r_cv[6] <= r_cv[6] ^ rotl(r_v[5], 5'd19);
            r_cv[7] <= r_cv[7] ^ r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            for (int k = 0; k < 16; k++) r_w[k] <= i_block[32*k +: 32];
            for (int k = 0; k < 8; k++) r_v[k] <= r_cv[k];
        end else if (r_busy) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= wn;
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= rotl(r_v[1], 5'd9);
            r_v[3] <= r_v[2];
            r_v[4] <= perm0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= rotl(r_v[5], 5'd19);
            r_v[7] <= r_v[6];
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) o_cv[32*k +: 32] = r_cv[k];
    end
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule
